/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* design/ipv4pv_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4pv_pkg
// Shared types and constants of the Ethernet / IPv4 frame validator
// ----------------------------------------------------------------------------
package ipv4pv_pkg;

   // frame length limit where the byte counter saturates
   localparam int unsigned MAX_FRAME_BYTES = 2048;
   localparam int unsigned CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_FRAME_BYTES);

   // byte positions within the frame
   localparam logic [CNT_W-1:0] POS_TYPE_HI   = CNT_W'(12);
   localparam logic [CNT_W-1:0] POS_TYPE_LO   = CNT_W'(13);
   localparam logic [CNT_W-1:0] POS_IP_START  = CNT_W'(14);
   localparam logic [CNT_W-1:0] POS_PROTO     = CNT_W'(23);
   localparam logic [CNT_W-1:0] POS_HCSUM_HI  = CNT_W'(24);
   localparam logic [CNT_W-1:0] POS_HCSUM_LO  = CNT_W'(25);
   localparam logic [CNT_W-1:0] POS_PAY_START = CNT_W'(34);
   localparam logic [CNT_W-1:0] POS_ICMP_HI   = CNT_W'(36);
   localparam logic [CNT_W-1:0] POS_ICMP_LO   = CNT_W'(37);
   localparam logic [CNT_W-1:0] POS_OSPF_HI   = CNT_W'(46);
   localparam logic [CNT_W-1:0] POS_OSPF_LO   = CNT_W'(47);

   // minimum frame lengths
   localparam logic [CNT_W-1:0] MIN_LEN_ARP  = CNT_W'(42);
   localparam logic [CNT_W-1:0] MIN_LEN_IPV4 = CNT_W'(34);
   localparam logic [CNT_W-1:0] MIN_LEN_ICMP = CNT_W'(38);
   localparam logic [CNT_W-1:0] MIN_LEN_OSPF = CNT_W'(58);

   // ethertypes and protocol numbers
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_ARP  = 16'h0806;
   localparam logic [7:0]  PROTO_ICMP = 8'd1;
   localparam logic [7:0]  PROTO_OSPF = 8'd89;

   // one frame byte as held in the input register
   typedef struct packed {
      logic       last_byte;
      logic [7:0] data_byte;
   } item_type;

endpackage

/* design/ipv4pv_input_stage.sv */
// ----------------------------------------------------------------------------
// ipv4pv_input_stage
// Input register for one frame byte, refilled in the cycle it drains
// ----------------------------------------------------------------------------
module ipv4pv_input_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  ipv4pv_pkg::item_type req_item,
   input  logic                advance,
   output logic                item_valid,
   output ipv4pv_pkg::item_type item
);
   import ipv4pv_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // free when empty or when the held word moves on this cycle
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* design/ipv4pv_frame_state.sv */
// ----------------------------------------------------------------------------
// ipv4pv_frame_state
// Per-frame state, running ones'-complement sums and the frame verdict
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4pv_frame_state (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  ipv4pv_pkg::item_type item,
   output logic                verdict
);
   import ipv4pv_pkg::*;

   logic [CNT_W-1:0] count_ff,   count_in;
   logic [15:0]      ftype_ff,   ftype_in;
   logic [7:0]       proto_ff,   proto_in;
   logic [15:0]      hsum_ff,    hsum_in;
   logic [15:0]      psum_ff,    psum_in;
   logic [15:0]      hstore_ff,  hstore_in;
   logic [15:0]      pstore_ff,  pstore_in;
   logic [7:0]       pend_ff,    pend_in;
   logic             odd_ff,     odd_in;

   logic [7:0]  b;
   logic        in_hdr;
   logic        in_pay;
   logic        hfield;
   logic        pfield;
   logic [7:0]  hv;
   logic [7:0]  pv;
   logic [15:0] pword;
   logic [15:0] hcalc;
   logic [15:0] pcalc;
   logic        hdr_ok;

   // end-around carry add
   function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
      logic [16:0] s;
      s = {1'b0, acc} + {1'b0, word};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // complement of the sum, zero taken as all ones
   function automatic logic [15:0] finish_sum(input logic [15:0] acc);
      return (acc == 16'hffff) ? 16'hffff : ~acc;
   endfunction

   assign b      = item.data_byte;
   assign in_hdr = (count_ff >= POS_IP_START) && (count_ff < POS_PAY_START);
   assign in_pay = (count_ff >= POS_PAY_START);
   assign hfield = (count_ff == POS_HCSUM_HI) || (count_ff == POS_HCSUM_LO);
   assign pfield = ((proto_ff == PROTO_ICMP) &&
                    ((count_ff == POS_ICMP_HI) || (count_ff == POS_ICMP_LO))) ||
                   ((proto_ff == PROTO_OSPF) &&
                    ((count_ff == POS_OSPF_HI) || (count_ff == POS_OSPF_LO)));
   assign hv     = hfield ? 8'h00 : b;
   assign pv     = pfield ? 8'h00 : b;
   // odd position closes a word; an even last byte is padded as a high byte
   assign pword  = odd_ff ? {pend_ff, pv} : {pv, 8'h00};

   // next state for the byte at hand
   always_comb begin
      count_in  = (count_ff < CNT_MAX) ? count_ff + CNT_W'(1) : count_ff;
      odd_in    = !odd_ff;
      ftype_in  = ftype_ff;
      proto_in  = proto_ff;
      hsum_in   = hsum_ff;
      psum_in   = psum_ff;
      hstore_in = hstore_ff;
      pstore_in = pstore_ff;
      pend_in   = pend_ff;

      if (count_ff == POS_TYPE_HI) begin
         ftype_in = {b, 8'h00};
      end else if (count_ff == POS_TYPE_LO) begin
         ftype_in = ftype_ff | {8'h00, b};
      end
      if (count_ff == POS_PROTO) begin
         proto_in = b;
      end

      if (in_hdr) begin
         if (hfield) begin
            hstore_in = {hstore_ff[7:0], b};
         end
         if (odd_ff) begin
            hsum_in = oc_add(hsum_ff, {pend_ff, hv});
         end else begin
            pend_in = hv;
         end
      end else if (in_pay) begin
         if (pfield) begin
            pstore_in = {pstore_ff[7:0], b};
         end
         if (!odd_ff) begin
            pend_in = pv;
         end
         if (odd_ff || item.last_byte) begin
            psum_in = oc_add(psum_ff, pword);
         end
      end
   end

   // verdict from the state after this byte
   assign hcalc  = finish_sum(hsum_in);
   assign pcalc  = finish_sum(psum_in);
   assign hdr_ok = (count_in >= MIN_LEN_IPV4) && (hcalc == hstore_in);

   always_comb begin
      verdict = 1'b0;
      if (ftype_in == ETYPE_ARP) begin
         verdict = (count_in >= MIN_LEN_ARP);
      end else if (ftype_in == ETYPE_IPV4 && hdr_ok) begin
         if (proto_in == PROTO_ICMP) begin
            verdict = (count_in >= MIN_LEN_ICMP) && (pcalc == pstore_in);
         end else if (proto_in == PROTO_OSPF) begin
            verdict = (count_in >= MIN_LEN_OSPF) && (pcalc == pstore_in);
         end else begin
            verdict = 1'b1;
         end
      end
   end

   // state registers, cleared after each verdict
   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         count_ff  <= '0;
         ftype_ff  <= '0;
         proto_ff  <= '0;
         hsum_ff   <= '0;
         psum_ff   <= '0;
         hstore_ff <= '0;
         pstore_ff <= '0;
         pend_ff   <= '0;
         odd_ff    <= 1'b0;
      end else if (step) begin
         count_ff  <= count_in;
         ftype_ff  <= ftype_in;
         proto_ff  <= proto_in;
         hsum_ff   <= hsum_in;
         psum_ff   <= psum_in;
         hstore_ff <= hstore_in;
         pstore_ff <= pstore_in;
         pend_ff   <= pend_in;
         odd_ff    <= odd_in;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= CNT_MAX), "byte count beyond limit")
   `ASSERT_CLK(a_clear_after_last, clock, reset, step && item.last_byte |=> count_ff == '0, "state not cleared after last byte")
   `ASSERT_CLK(a_parity_track, clock, reset, count_ff < CNT_MAX |-> odd_ff == count_ff[0], "word parity out of step with count")

endmodule

/* design/ipv4pv_output_stage.sv */
// ----------------------------------------------------------------------------
// ipv4pv_output_stage
// Result register holding one verdict until the sink takes it
// ----------------------------------------------------------------------------
module ipv4pv_output_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic       verdict,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata
);
   logic valid_ff;
   logic valid_in;
   logic verdict_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= verdict;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, verdict_ff};

endmodule

/* design/ethernet_ipv4_packet_validator_unit.sv */
// ----------------------------------------------------------------------------
// ethernet_ipv4_packet_validator_unit
// Checks ARP / IPv4 frame lengths and IPv4, ICMP and OSPF checksums
// ----------------------------------------------------------------------------
//  channel  dir  payload                          handshake
//  req      in   tdata[7:0] frame byte, tlast     req_tvalid / req_tready
//  rsp      out  tdata[0] packet valid            rsp_tvalid / rsp_tready
//
//  one byte per cycle sustained, except for the stall below; the verdict for the last
//  byte passes the input register, then the state update into the result register
//  per-byte work is at most one end-around carry add, to one running sum
//  reset is synchronous and clears all frame state and both valid flags
//  the input stalls only while a last byte waits on a full result register
// ----------------------------------------------------------------------------
module ethernet_ipv4_packet_validator_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] packet_valid, [7:1] zero
);
   import ipv4pv_pkg::*;

   item_type req_item;
   item_type item;
   logic     item_valid;
   logic     advance;
   logic     verdict;

   assign req_item.data_byte = req_tdata;
   assign req_item.last_byte = req_tlast;

   // a held byte moves on unless it is a last byte facing a full result slot
   assign advance = item_valid && (!item.last_byte || !rsp_tvalid || rsp_tready);

   ipv4pv_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ipv4pv_frame_state u_state (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (item),
      .verdict (verdict)
   );

   ipv4pv_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && item.last_byte),
      .verdict    (verdict),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
